>>> hdl/stsp_pkg.sv
// Shared types and constants of the slide transition slice planner.
package stsp_pkg;

    // field widths
    localparam int X_W       = 10;  // columns, widths
    localparam int Y_W       = 9;   // rows, heights
    localparam int DUR_W     = 16;  // duration in ms
    localparam int ELAPSED_W = 32;  // elapsed time in ms
    localparam int MODE_W    = 3;
    localparam int FRAC_W    = 10;  // progress is q / 1024
    localparam int Q_W       = FRAC_W;  // quotient bits while not finished

    // full progress (1024)
    localparam logic [Q_W:0] Q_FULL = (Q_W + 1)'(1) << FRAC_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_L   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_T   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_H   = 3'd5;

    // transition modes
    localparam logic [MODE_W-1:0] MODE_H_PUSH_IN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_H_PUSH_OUT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_H_SLIDE_IN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_H_SLIDE_OUT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_V_SLIDE_IN  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_V_SLIDE_OUT = 3'd5;

    // request kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // register reset values
    localparam logic [DUR_W-1:0] RST_DURATION = 16'd1;
    localparam logic [X_W-1:0]   RST_RECT_W   = 10'd800;
    localparam logic [Y_W-1:0]   RST_RECT_H   = 9'd480;

    // one copy request on the output side
    typedef struct packed {
        logic           from_new_frame;
        logic [X_W-1:0] src_x;
        logic [Y_W-1:0] src_y;
        logic [X_W-1:0] dst_x;
        logic [Y_W-1:0] dst_y;
        logic [X_W-1:0] copy_width;
        logic [Y_W-1:0] copy_height;
        logic           last;
        logic           final_frame;
    } t_copy;

endpackage

>>> hdl/stsp_if.sv
// Valid/ready channel interfaces: input requests, copy requests, register writes.
interface stsp_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [stsp_pkg::ELAPSED_W-1:0]  elapsed_ms;

    modport source (output valid, action, elapsed_ms, input ready);
    modport sink   (input valid, action, elapsed_ms, output ready);
endinterface

interface stsp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        from_new_frame;
    logic [stsp_pkg::X_W-1:0]    src_x;
    logic [stsp_pkg::Y_W-1:0]    src_y;
    logic [stsp_pkg::X_W-1:0]    dst_x;
    logic [stsp_pkg::Y_W-1:0]    dst_y;
    logic [stsp_pkg::X_W-1:0]    copy_width;
    logic [stsp_pkg::Y_W-1:0]    copy_height;
    logic                        last;
    logic                        final_frame;

    modport source (output valid, from_new_frame, src_x, src_y, dst_x, dst_y,
                    copy_width, copy_height, last, final_frame, input ready);
    modport sink   (input valid, from_new_frame, src_x, src_y, dst_x, dst_y,
                    copy_width, copy_height, last, final_frame, output ready);
endinterface

interface stsp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [stsp_pkg::CFG_IDX_W-1:0]    index;
    logic [stsp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/stsp_div.sv
// Bit-serial restoring divider: num * 2^Q_W / den, one quotient bit per cycle.
module stsp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stsp_pkg::DUR_W-1:0]    i_num,   // must be below i_den
    input  logic [stsp_pkg::DUR_W-1:0]    i_den,
    output logic                          o_done,
    output logic [stsp_pkg::Q_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(stsp_pkg::Q_W + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [stsp_pkg::DUR_W-1:0]    r_rem;
    logic [stsp_pkg::DUR_W-1:0]    r_den;
    logic [stsp_pkg::Q_W-1:0]      r_quot;

    logic [stsp_pkg::DUR_W:0]      w_shift;
    logic [stsp_pkg::DUR_W:0]      w_diff;
    logic                          w_ge;
    logic [stsp_pkg::DUR_W-1:0]    n_rem;

    // remainder stays below den, so the doubled value fits one extra bit
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = w_shift >= {1'b0, r_den};
        n_rem   = w_ge ? w_diff[stsp_pkg::DUR_W-1:0] : w_shift[stsp_pkg::DUR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(stsp_pkg::Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[stsp_pkg::Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hdl/stsp_mul.sv
// Bit-serial shift-add multiplier: extent * q / 2^FRAC_W, one bit of q per cycle.
module stsp_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stsp_pkg::X_W-1:0]      i_mcand,
    input  logic [stsp_pkg::Q_W:0]        i_mplier,
    output logic                          o_done,
    output logic [stsp_pkg::X_W-1:0]      o_scaled
);
    localparam int STEPS  = stsp_pkg::Q_W + 1;
    localparam int PROD_W = stsp_pkg::X_W + STEPS;
    localparam int CNT_W  = $clog2(STEPS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [PROD_W-1:0]      r_prod;
    logic [PROD_W-1:0]      r_addend;
    logic [STEPS-1:0]       r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod   <= '0;
            r_addend <= PROD_W'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_addend;
            end
            r_addend <= {r_addend[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[STEPS-1:1]};
        end
    end

    assign o_done   = r_done;
    // product never exceeds extent * 2^FRAC_W, so X_W bits remain
    assign o_scaled = r_prod[stsp_pkg::FRAC_W +: stsp_pkg::X_W];

endmodule

>>> hdl/slide_transition_slice_planner.sv
// Top level: plans the old-image and new-image copy rectangles of a slide transition.
// Start request: accepted while idle, produces no copy requests, and leaves the input ready.
// Tick request: runs the serial divider (skipped on the final tick), then the serial
//   multiplier, then the planning state; the input is ready again once the plan lands.
// Planning waits for the two-entry copy queue to drain; copies turn valid with ready.
// Synchronous active-low reset clears control state and the queue.
module slide_transition_slice_planner #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stsp_cfg_if.sink    i_cfg,
    stsp_in_if.sink     i_in,
    stsp_out_if.source  o_out
);
    localparam int PW_BITS = $clog2(PANEL_WIDTH + 1);
    localparam int PH_BITS = $clog2(PANEL_HEIGHT + 1);
    localparam int XS_W = (PW_BITS > stsp_pkg::X_W + 1) ? PW_BITS : stsp_pkg::X_W + 1;
    localparam int YS_W = (PH_BITS > stsp_pkg::Y_W + 1) ? PH_BITS : stsp_pkg::Y_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_PLAN = 4'b1000
    } t_state;

    // configuration registers
    logic [stsp_pkg::MODE_W-1:0]  r_mode;
    logic [stsp_pkg::DUR_W-1:0]   r_duration;
    logic [stsp_pkg::X_W-1:0]     r_rect_left;
    logic [stsp_pkg::Y_W-1:0]     r_rect_top;
    logic [stsp_pkg::X_W-1:0]     r_rect_width;
    logic [stsp_pkg::Y_W-1:0]     r_rect_height;

    // transition state
    t_state                       r_state;
    logic                         r_running;
    logic [stsp_pkg::X_W-1:0]     r_prev;   // previous offset
    logic                         r_fin;    // this tick ends the transition
    logic [stsp_pkg::X_W-1:0]     r_d;      // offset of this tick

    // output queue, head in slot 0
    stsp_pkg::t_copy              r_q0;
    stsp_pkg::t_copy              r_q1;
    logic [1:0]                   r_qcnt;

    logic                         w_in_acc;
    logic                         w_out_acc;
    logic                         w_mode_ok;
    logic                         w_start_ok;
    logic [XS_W-1:0]              w_x_end;
    logic [YS_W-1:0]              w_y_end;
    logic [stsp_pkg::DUR_W-1:0]   w_dur;
    logic                         w_fin_now;
    logic                         w_vertical;
    logic [stsp_pkg::X_W-1:0]     w_extent;

    logic                         w_div_start;
    logic                         w_div_done;
    logic [stsp_pkg::Q_W-1:0]     w_div_quot;
    logic                         w_mul_start;
    logic [stsp_pkg::Q_W:0]       w_mul_q;
    logic                         w_mul_done;
    logic [stsp_pkg::X_W-1:0]     w_mul_d;
    logic [stsp_pkg::X_W-1:0]     n_d;

    // copy geometry; heights kept 10 bits wide for the empty test
    logic [stsp_pkg::X_W-1:0]     w_rest_w;
    logic [stsp_pkg::Y_W-1:0]     w_rest_h;
    logic [stsp_pkg::X_W-1:0]     w_a_sx, w_a_dx, w_a_w, w_b_sx, w_b_dx, w_b_w;
    logic [stsp_pkg::Y_W-1:0]     w_a_sy, w_a_dy, w_b_sy, w_b_dy;
    logic [stsp_pkg::X_W-1:0]     w_a_h, w_b_h;
    logic                         w_a_ok, w_b_ok;
    stsp_pkg::t_copy              w_copy_a, w_copy_b;
    logic                         w_load;

    assign w_in_acc  = i_in.valid & i_in.ready;
    assign w_out_acc = o_out.valid & o_out.ready;

    // ---------------------------------------------------------------
    // Register writes; the port never stalls. Unknown indexes are dropped.
    // ---------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= stsp_pkg::MODE_H_PUSH_IN;
            r_duration    <= stsp_pkg::RST_DURATION;
            r_rect_left   <= '0;
            r_rect_top    <= '0;
            r_rect_width  <= stsp_pkg::RST_RECT_W;
            r_rect_height <= stsp_pkg::RST_RECT_H;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                stsp_pkg::CFG_MODE:     r_mode        <= i_cfg.data[stsp_pkg::MODE_W-1:0];
                stsp_pkg::CFG_DURATION: r_duration    <= i_cfg.data[stsp_pkg::DUR_W-1:0];
                stsp_pkg::CFG_RECT_L:   r_rect_left   <= i_cfg.data[stsp_pkg::X_W-1:0];
                stsp_pkg::CFG_RECT_T:   r_rect_top    <= i_cfg.data[stsp_pkg::Y_W-1:0];
                stsp_pkg::CFG_RECT_W:   r_rect_width  <= i_cfg.data[stsp_pkg::X_W-1:0];
                stsp_pkg::CFG_RECT_H:   r_rect_height <= i_cfg.data[stsp_pkg::Y_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    always_comb begin
        w_mode_ok  = r_mode <= stsp_pkg::MODE_V_SLIDE_OUT;
        w_x_end    = XS_W'(r_rect_left) + XS_W'(r_rect_width);
        w_y_end    = YS_W'(r_rect_top) + YS_W'(r_rect_height);
        // rectangle must be non-empty and fit the panel
        w_start_ok = w_mode_ok && (r_rect_width != '0) && (r_rect_height != '0)
                     && (w_x_end <= XS_W'(PANEL_WIDTH)) && (w_y_end <= YS_W'(PANEL_HEIGHT));
        // zero duration behaves as 1 ms
        w_dur      = (r_duration == '0) ? stsp_pkg::DUR_W'(1) : r_duration;
        w_fin_now  = (|i_in.elapsed_ms[stsp_pkg::ELAPSED_W-1:stsp_pkg::DUR_W])
                     || (i_in.elapsed_ms[stsp_pkg::DUR_W-1:0] >= w_dur);
        w_vertical = (r_mode == stsp_pkg::MODE_V_SLIDE_IN)
                     || (r_mode == stsp_pkg::MODE_V_SLIDE_OUT);
        w_extent   = w_vertical ? stsp_pkg::X_W'(r_rect_height) : r_rect_width;
    end

    // a tick that goes to the arithmetic units
    logic w_tick_go;
    assign w_tick_go = w_in_acc && (i_in.action == stsp_pkg::ACT_TICK) && r_running
                       && w_mode_ok;

    // progress = elapsed * 1024 / duration, only while elapsed < duration
    assign w_div_start = w_tick_go && !w_fin_now;
    // offset = extent * progress / 1024; final tick uses full progress
    assign w_mul_start = (w_tick_go && w_fin_now) || ((r_state == ST_DIV) && w_div_done);
    assign w_mul_q     = (r_state == ST_IDLE) ? stsp_pkg::Q_FULL : {1'b0, w_div_quot};

    stsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (i_in.elapsed_ms[stsp_pkg::DUR_W-1:0]),
        .i_den   (w_dur),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    stsp_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_extent),
        .i_mplier (w_mul_q),
        .o_done   (w_mul_done),
        .o_scaled (w_mul_d)
    );

    // offset never moves back
    assign n_d = (w_mul_d < r_prev) ? r_prev : w_mul_d;

    // ---------------------------------------------------------------
    // Slice geometry from the registered offset
    // ---------------------------------------------------------------
    always_comb begin
        w_rest_w = (r_d <= r_rect_width) ? (r_rect_width - r_d) : '0;
        w_rest_h = (r_d <= stsp_pkg::X_W'(r_rect_height))
                   ? (r_rect_height - r_d[stsp_pkg::Y_W-1:0]) : '0;

        w_a_sx = r_rect_left;  w_a_dx = r_rect_left;
        w_a_sy = r_rect_top;   w_a_dy = r_rect_top;
        w_a_w  = r_rect_width; w_a_h  = stsp_pkg::X_W'(r_rect_height);
        w_b_sx = r_rect_left;  w_b_dx = r_rect_left;
        w_b_sy = r_rect_top;   w_b_dy = r_rect_top;
        w_b_w  = r_rect_width; w_b_h  = stsp_pkg::X_W'(r_rect_height);

        unique case (r_mode)
            stsp_pkg::MODE_H_PUSH_IN: begin
                // old image scrolls by this tick's step, new image enters at right
                w_a_sx = r_rect_left + (r_d - r_prev);
                w_a_w  = w_rest_w;
                w_b_dx = r_rect_left + w_rest_w;
                w_b_w  = r_d;
            end
            stsp_pkg::MODE_H_PUSH_OUT: begin
                w_a_sx = r_rect_left + r_prev;
                w_a_dx = r_rect_left + r_d;
                w_a_w  = w_rest_w;
                w_b_sx = r_rect_left + w_rest_w;
                w_b_w  = r_d;
            end
            stsp_pkg::MODE_H_SLIDE_IN: begin
                w_a_w  = w_rest_w;
                w_b_dx = r_rect_left + w_rest_w;
                w_b_w  = r_d;
            end
            stsp_pkg::MODE_H_SLIDE_OUT: begin
                w_a_sx = r_rect_left + r_prev;
                w_a_dx = r_rect_left + r_d;
                w_a_w  = w_rest_w;
                w_b_w  = r_d;
            end
            stsp_pkg::MODE_V_SLIDE_IN: begin
                w_a_h  = stsp_pkg::X_W'(w_rest_h);
                w_b_dy = r_rect_top + w_rest_h;
                w_b_h  = r_d;
            end
            default: begin
                // vertical slide out
                w_a_sy = r_rect_top + r_prev[stsp_pkg::Y_W-1:0];
                w_a_dy = r_rect_top + r_d[stsp_pkg::Y_W-1:0];
                w_a_h  = stsp_pkg::X_W'(w_rest_h);
                w_b_h  = r_d;
            end
        endcase

        // empty copies are dropped
        w_a_ok = (w_a_w != '0) && (w_a_h != '0);
        w_b_ok = (w_b_w != '0) && (w_b_h != '0);

        w_copy_a = '{from_new_frame: 1'b0, src_x: w_a_sx, src_y: w_a_sy,
                     dst_x: w_a_dx, dst_y: w_a_dy, copy_width: w_a_w,
                     copy_height: w_a_h[stsp_pkg::Y_W-1:0], last: !w_b_ok,
                     final_frame: r_fin};
        w_copy_b = '{from_new_frame: 1'b1, src_x: w_b_sx, src_y: w_b_sy,
                     dst_x: w_b_dx, dst_y: w_b_dy, copy_width: w_b_w,
                     copy_height: w_b_h[stsp_pkg::Y_W-1:0], last: 1'b1,
                     final_frame: r_fin};
    end

    // plan lands once the queue has drained
    assign w_load = (r_state == ST_PLAN) && (r_qcnt == 2'd0);

    // ---------------------------------------------------------------
    // Sequencer and transition state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_running <= 1'b0;
            r_prev    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.action == stsp_pkg::ACT_START) begin
                            // start while running is ignored
                            if (!r_running && w_start_ok) begin
                                r_prev    <= '0;
                                r_running <= 1'b1;
                            end
                        end else if (r_running) begin
                            if (!w_mode_ok) begin
                                r_running <= 1'b0;  // bad mode aborts
                            end else if (w_fin_now) begin
                                r_state <= ST_MUL;
                            end else begin
                                r_state <= ST_DIV;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (w_mul_done) begin
                        r_state <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    if (w_load) begin
                        r_prev <= r_d;
                        if (r_fin) begin
                            r_running <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick_go) begin
            r_fin <= w_fin_now;
        end
        if ((r_state == ST_MUL) && w_mul_done) begin
            r_d <= n_d;
        end
    end

    // ---------------------------------------------------------------
    // Output queue
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else if (w_load) begin
            r_qcnt <= 2'(w_a_ok) + 2'(w_b_ok);
        end else if (w_out_acc) begin
            r_qcnt <= r_qcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_q0 <= w_a_ok ? w_copy_a : w_copy_b;
            r_q1 <= w_copy_b;
        end else if (w_out_acc) begin
            r_q0 <= r_q1;
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);

    assign o_out.valid          = (r_qcnt != 2'd0);
    assign o_out.from_new_frame = r_q0.from_new_frame;
    assign o_out.src_x          = r_q0.src_x;
    assign o_out.src_y          = r_q0.src_y;
    assign o_out.dst_x          = r_q0.dst_x;
    assign o_out.dst_y          = r_q0.dst_y;
    assign o_out.copy_width     = r_q0.copy_width;
    assign o_out.copy_height    = r_q0.copy_height;
    assign o_out.last           = r_q0.last;
    assign o_out.final_frame    = r_q0.final_frame;

endmodule

>>> hdl/stsp_checker.sv
// Port-level checks of the slice planner and their binding to the top level.
module stsp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_from_new_frame,
    input logic [stsp_pkg::X_W-1:0]    i_out_src_x,
    input logic [stsp_pkg::X_W-1:0]    i_out_dst_x,
    input logic [stsp_pkg::X_W-1:0]    i_out_copy_width,
    input logic                        i_out_last,
    input logic                        i_out_final_frame
);
    logic w_out_acc;
    assign w_out_acc = i_out_valid & i_out_ready;

    // stalled copy request stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("copy request dropped while stalled");

    // stalled copy request keeps its geometry
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_src_x) && $stable(i_out_dst_x) && $stable(i_out_copy_width))
        else $error("copy request changed while stalled");

    // horizontal sizes are never empty
    a_width_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_copy_width != '0)
        else $error("empty copy width");

    // a non-last copy is the old image and is followed at once by the new image
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !i_out_last |->
            !i_out_from_new_frame ##1 (i_out_valid && i_out_from_new_frame
                && i_out_final_frame == $past(i_out_final_frame)))
        else $error("copy pair out of order");

endmodule

bind slide_transition_slice_planner stsp_checker u_stsp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_from_new_frame (o_out.from_new_frame),
    .i_out_src_x          (o_out.src_x),
    .i_out_dst_x          (o_out.dst_x),
    .i_out_copy_width     (o_out.copy_width),
    .i_out_last           (o_out.last),
    .i_out_final_frame    (o_out.final_frame)
);
